// File: src/lci_pkg.sv
// Shared types, constants and codes of the loudness curve interpolator.
package lci_pkg;

   // Default number of curve point slots.
   localparam int MAX_POINTS_DEF = 16;

   // Field widths of the transaction payloads.
   localparam int STEP_W   = 10;
   localparam int SLOT_W   = 4;
   localparam int GAIN_W   = 16;
   localparam int PCOUNT_W = 5;

   // Interpolation arithmetic: product of a step distance and a gain distance.
   localparam int MAG_W  = GAIN_W;
   localparam int PROD_W = STEP_W + MAG_W;
   localparam int QUOT_W = MAG_W;

   // Queue between the front and the back; the depth is a power of two.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_POINT_COUNT = '0;
   localparam logic [PCOUNT_W-1:0]   POINT_COUNT_RST = PCOUNT_W'(1);

   // Command codes of an input transaction.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Position codes of a result transaction.
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_INTERP = 2'd1;
   localparam logic [1:0] POS_BEYOND = 2'd2;
   localparam logic [1:0] POS_WRITE  = 2'd3;

   // Operation decided by the front for each queued item.
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_SKIP,
      OP_QUERY
   } lci_op_type;

   // Sequencer states of the back.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIFF,
      ST_MUL,
      ST_DIVGO,
      ST_DIV
   } lci_state_type;

   typedef struct packed {
      logic                     cmd;
      logic [SLOT_W-1:0]        point_index;
      logic [STEP_W-1:0]        volume;
      logic signed [GAIN_W-1:0] bass_in;
      logic signed [GAIN_W-1:0] treble_in;
   } lci_req_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] bass_gain;
      logic signed [GAIN_W-1:0] treble_gain;
      logic [1:0]               position;
   } lci_rsp_type;

   typedef struct packed {
      lci_op_type               op;
      logic [SLOT_W-1:0]        slot;
      logic [STEP_W-1:0]        volume;
      logic signed [GAIN_W-1:0] bass;
      logic signed [GAIN_W-1:0] treble;
   } lci_item_type;

   typedef struct packed {
      logic [STEP_W-1:0]        step;
      logic signed [GAIN_W-1:0] bass;
      logic signed [GAIN_W-1:0] treble;
   } lci_point_type;

endpackage

// File: src/loudness_curve_interpolator_top.sv
// Top level of the loudness curve interpolator: register port, front and back.
//
// Usage: a transaction is taken on req_data when start is high and busy is low.
// A write command stores one curve point (volume step, bass and treble gain in
// signed Q8.8 dB); a query returns both gains for a volume, taken from the
// first point, from the last point, or interpolated between two neighbors.
// Every transaction gives exactly one result on rsp_data, shown for a single
// cycle with rsp_strobe high; the receiver cannot stall, so results are never
// held back. busy rises only when the two-entry queue between front and back
// is full, so new transactions are taken while earlier ones are in work.
// A query searches the points in order from point 0; an interpolated query then
// goes through the difference, the multiply and the 16-step divide. The back
// handles one item at a time.
// point_count sits at byte address 0 of the register port; it is to be written
// only while the block is idle, and the block itself does not enforce this.
// Reset clears the queue, the sequencer and sets point_count to 1; curve points
// are undefined until written.
module loudness_curve_interpolator_top #(
   parameter int MAX_POINTS = lci_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lci_pkg::lci_req_type              req_data,
   output logic                              rsp_strobe,
   output lci_pkg::lci_rsp_type              rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lci_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lci_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lci_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   logic [lci_pkg::PCOUNT_W-1:0] point_count_ff, point_count_in;
   logic                         csr_hit;
   logic                         item_valid;
   logic                         pop;
   lci_pkg::lci_item_type        item;

   // Register decode and write.
   assign pready  = 1'b1;
   assign csr_hit = (paddr[lci_pkg::CSR_ADDR_W-1:2] == lci_pkg::REG_POINT_COUNT);

   always_comb begin
      point_count_in = point_count_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         point_count_in = pwdata[lci_pkg::PCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= lci_pkg::POINT_COUNT_RST;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   // Register read.
   always_comb begin
      prdata = '0;
      if (csr_hit) begin
         prdata = lci_pkg::CSR_DATA_W'(point_count_ff);
      end
   end

   lci_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .pop        (pop)
   );

   lci_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .pop         (pop),
      .point_count (point_count_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

// File: src/lci_div.sv
// Restoring divider that produces one quotient bit per cycle.
module lci_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lci_pkg::PROD_W-1:0]   dividend,
   input  logic [lci_pkg::STEP_W-1:0]   divisor,
   output logic                         done,
   output logic [lci_pkg::QUOT_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(lci_pkg::QUOT_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [lci_pkg::STEP_W-1:0]    rem_ff, rem_in;
   logic [lci_pkg::QUOT_W-1:0]    work_ff, work_in;
   logic [lci_pkg::STEP_W-1:0]    den_ff, den_in;
   logic [lci_pkg::STEP_W:0]      partial;
   logic [lci_pkg::STEP_W:0]      trial;
   logic                          fits;

   // One trial subtraction of the divisor from the shifted remainder.
   // The upper dividend bits are below the divisor, so QUOT_W steps suffice.
   always_comb begin
      partial = {rem_ff, work_ff[lci_pkg::QUOT_W-1]};
      trial   = partial - {1'b0, den_ff};
      fits    = (partial >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[lci_pkg::PROD_W-1:lci_pkg::QUOT_W];
         work_in = dividend[lci_pkg::QUOT_W-1:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[lci_pkg::STEP_W-1:0] : partial[lci_pkg::STEP_W-1:0];
         work_in = {work_ff[lci_pkg::QUOT_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(lci_pkg::QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// File: src/lci_front.sv
// Front end: accepts transactions, classifies them and queues them for the back.
module lci_front #(
   parameter int MAX_POINTS = lci_pkg::MAX_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lci_pkg::lci_req_type  req_data,
   output logic                  item_valid,
   output lci_pkg::lci_item_type item,
   input  logic                  pop
);

   localparam int QPTR_W = (lci_pkg::QUEUE_DEPTH > 1) ? $clog2(lci_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(lci_pkg::QUEUE_DEPTH + 1);

   lci_pkg::lci_item_type queue_ff [lci_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                  accept;
   lci_pkg::lci_item_type classified;

   // Decide what the back has to do with the incoming transaction.
   always_comb begin
      classified.slot   = req_data.point_index;
      classified.volume = req_data.volume;
      classified.bass   = req_data.bass_in;
      classified.treble = req_data.treble_in;
      if (req_data.cmd == lci_pkg::CMD_QUERY) begin
         classified.op = lci_pkg::OP_QUERY;
      end else if (32'(req_data.point_index) < 32'(MAX_POINTS)) begin
         classified.op = lci_pkg::OP_WRITE;
      end else begin
         classified.op = lci_pkg::OP_SKIP;
      end
   end

   // Queue bookkeeping.
   assign busy   = (cnt_ff == QCNT_W'(lci_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (accept && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !accept) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (accept) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   assign item_valid = (cnt_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

endmodule

// File: src/lci_back.sv
// Back end: curve memory, sequential search and serial interpolation.
module lci_back #(
   parameter int MAX_POINTS = lci_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  lci_pkg::lci_item_type         item,
   output logic                          pop,
   input  logic [lci_pkg::PCOUNT_W-1:0]  point_count,
   output logic                          rsp_strobe,
   output lci_pkg::lci_rsp_type          rsp_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int GW = lci_pkg::GAIN_W;

   lci_pkg::lci_point_type curve_mem_ff [MAX_POINTS];
   lci_pkg::lci_point_type rdata_ff;
   lci_pkg::lci_point_type prev_ff;

   lci_pkg::lci_state_type state_ff, state_in;
   logic [NW-1:0]          idx_ff, idx_in;
   logic [NW-1:0]          cmp_idx_ff;
   logic [NW-1:0]          n_ff;
   logic                   rd_vld_ff;
   logic [lci_pkg::STEP_W-1:0] vol_ff;

   logic [lci_pkg::STEP_W-1:0] num_ff, den_ff;
   logic [lci_pkg::MAG_W-1:0]  mag_b_ff, mag_t_ff;
   logic                       neg_b_ff, neg_t_ff;
   logic [lci_pkg::PROD_W-1:0] prod_b_ff, prod_t_ff;

   logic                       rsp_strobe_ff;
   lci_pkg::lci_rsp_type       rsp_ff;

   logic [31:0]                n_sat;
   logic                       issue, hit, last, at_first;
   logic                       mem_we, rd_en, load_prev, load_query;
   logic                       div_start, rsp_load;
   lci_pkg::lci_rsp_type       rsp_next;
   logic                       div_done_b, div_done_t;
   logic [lci_pkg::QUOT_W-1:0] quot_b, quot_t;
   logic signed [GW:0]         diff_b, diff_t;
   logic [GW:0]                sum_b, sum_t;

   // Points in use: zero counts as one, large values saturate.
   always_comb begin
      n_sat = 32'(point_count);
      if (n_sat == 32'd0) begin
         n_sat = 32'd1;
      end else if (n_sat > 32'(MAX_POINTS)) begin
         n_sat = 32'(MAX_POINTS);
      end
   end

   // Search status of the entry that the memory delivers this cycle.
   assign issue    = (idx_ff < n_ff);
   assign hit      = rd_vld_ff && (rdata_ff.step >= vol_ff);
   assign last     = rd_vld_ff && (cmp_idx_ff == n_ff - NW'(1));
   assign at_first = (cmp_idx_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lci_pkg::ST_IDLE: begin
            if (item_valid && item.op == lci_pkg::OP_QUERY) begin
               state_in = lci_pkg::ST_SEARCH;
            end
         end
         lci_pkg::ST_SEARCH: begin
            if (hit && at_first) begin
               state_in = lci_pkg::ST_IDLE;
            end else if (hit) begin
               state_in = lci_pkg::ST_DIFF;
            end else if (last) begin
               state_in = lci_pkg::ST_IDLE;
            end
         end
         lci_pkg::ST_DIFF:  state_in = lci_pkg::ST_MUL;
         lci_pkg::ST_MUL:   state_in = lci_pkg::ST_DIVGO;
         lci_pkg::ST_DIVGO: state_in = lci_pkg::ST_DIV;
         lci_pkg::ST_DIV: begin
            if (div_done_b) begin
               state_in = lci_pkg::ST_IDLE;
            end
         end
         default: state_in = lci_pkg::ST_IDLE;
      endcase
   end

   // Interpolated gains: first gain plus the signed quotient.
   always_comb begin
      sum_b = {prev_ff.bass[GW-1], prev_ff.bass}
            + (neg_b_ff ? -{1'b0, quot_b} : {1'b0, quot_b});
      sum_t = {prev_ff.treble[GW-1], prev_ff.treble}
            + (neg_t_ff ? -{1'b0, quot_t} : {1'b0, quot_t});
   end

   // Sequencer outputs.
   always_comb begin
      pop        = 1'b0;
      mem_we     = 1'b0;
      rd_en      = 1'b0;
      load_prev  = 1'b0;
      load_query = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      rsp_next   = '0;
      unique case (state_ff)
         lci_pkg::ST_IDLE: begin
            if (item_valid) begin
               pop = 1'b1;
               rsp_next.position = lci_pkg::POS_WRITE;
               case (item.op)
                  lci_pkg::OP_WRITE: begin
                     mem_we   = 1'b1;
                     rsp_load = 1'b1;
                  end
                  lci_pkg::OP_QUERY: load_query = 1'b1;
                  default:           rsp_load   = 1'b1;
               endcase
            end
         end
         lci_pkg::ST_SEARCH: begin
            if (hit && at_first) begin
               rsp_load             = 1'b1;
               rsp_next.bass_gain   = rdata_ff.bass;
               rsp_next.treble_gain = rdata_ff.treble;
               rsp_next.position    = lci_pkg::POS_FIRST;
            end else if (!hit && last) begin
               rsp_load             = 1'b1;
               rsp_next.bass_gain   = rdata_ff.bass;
               rsp_next.treble_gain = rdata_ff.treble;
               rsp_next.position    = lci_pkg::POS_BEYOND;
            end else if (!hit) begin
               rd_en     = issue;
               load_prev = rd_vld_ff;
            end
         end
         lci_pkg::ST_DIVGO: div_start = 1'b1;
         lci_pkg::ST_DIV: begin
            if (div_done_b) begin
               rsp_load             = 1'b1;
               rsp_next.bass_gain   = sum_b[GW-1:0];
               rsp_next.treble_gain = sum_t[GW-1:0];
               rsp_next.position    = lci_pkg::POS_INTERP;
            end
         end
         default: ;
      endcase
   end

   assign idx_in = load_query ? '0 : (rd_en ? idx_ff + NW'(1) : idx_ff);

   // Gain distances between the neighboring points.
   always_comb begin
      diff_b = $signed({rdata_ff.bass[GW-1], rdata_ff.bass})
             - $signed({prev_ff.bass[GW-1], prev_ff.bass});
      diff_t = $signed({rdata_ff.treble[GW-1], rdata_ff.treble})
             - $signed({prev_ff.treble[GW-1], prev_ff.treble});
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lci_pkg::ST_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= rsp_load;
         idx_ff        <= idx_in;
      end
   end

   // Curve memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         curve_mem_ff[AW'(item.slot)] <= '{step: item.volume, bass: item.bass,
                                          treble: item.treble};
      end
      if (rd_en) begin
         rdata_ff   <= curve_mem_ff[idx_ff[AW-1:0]];
         cmp_idx_ff <= idx_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (load_query) begin
         vol_ff <= item.volume;
         n_ff   <= NW'(n_sat);
      end
      if (load_prev) begin
         prev_ff <= rdata_ff;
      end
      if (state_ff == lci_pkg::ST_DIFF) begin
         num_ff   <= vol_ff - prev_ff.step;
         den_ff   <= rdata_ff.step - prev_ff.step;
         neg_b_ff <= diff_b[GW];
         neg_t_ff <= diff_t[GW];
         mag_b_ff <= diff_b[GW] ? GW'(-diff_b) : GW'(diff_b);
         mag_t_ff <= diff_t[GW] ? GW'(-diff_t) : GW'(diff_t);
      end
      if (state_ff == lci_pkg::ST_MUL) begin
         prod_b_ff <= num_ff * mag_b_ff;
         prod_t_ff <= num_ff * mag_t_ff;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   lci_div u_div_bass (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_b_ff),
      .divisor  (den_ff),
      .done     (div_done_b),
      .quotient (quot_b)
   );

   lci_div u_div_treble (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_t_ff),
      .divisor  (den_ff),
      .done     (div_done_t),
      .quotient (quot_t)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A pending memory read always belongs to the search and a slot in use.
   a_read_in_search: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == lci_pkg::ST_SEARCH) && (cmp_idx_ff < n_ff))
      else $error("memory read outside of the search or past the points in use");

   // Both dividers run in lock step.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_done_b == div_done_t)
      else $error("bass and treble dividers finished on different cycles");

   // A quotient is only ready while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done_b |-> state_ff == lci_pkg::ST_DIV)
      else $error("divider finished outside of the divide state");

   // A result leaves the sequencer idle or back at the start of work.
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == lci_pkg::ST_IDLE || state_ff == lci_pkg::ST_IDLE
                        || $past(state_ff) == lci_pkg::ST_IDLE)
      else $error("result strobe while the sequencer is still busy");

endmodule
